// ===== design/htfd_pkg.sv =====
// htfd_pkg: shared types, constants and the crc-8 step function for the
// humidity and temperature frame decoder; depends on nothing
`default_nettype none

package htfd_pkg;

  // frame layout
  localparam int unsigned DATA_BYTES = 6;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned CODE_W     = 20;
  localparam int unsigned FRAC_BITS  = 20;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_STATUS  = 3'd0;
  localparam logic [POS_W-1:0] POS_HUM_HI  = 3'd1;
  localparam logic [POS_W-1:0] POS_HUM_MID = 3'd2;
  localparam logic [POS_W-1:0] POS_SPLIT   = 3'd3;
  localparam logic [POS_W-1:0] POS_TEMP_MID = 3'd4;
  localparam logic [POS_W-1:0] POS_CRC     = 3'd6;

  // crc-8, msb first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // fixed-point scaling
  localparam int unsigned HUM_CENTI_W  = 14;
  localparam int unsigned TEMP_CENTI_W = 15;
  localparam int unsigned HUM_PROD_W   = CODE_W + HUM_CENTI_W;
  localparam int unsigned TEMP_PROD_W  = CODE_W + TEMP_CENTI_W;
  localparam logic [HUM_CENTI_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_CENTI_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_CENTI_W:0]   TEMP_OFFSET = 16'd5000;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QADDR_W = $clog2(QDEPTH);

  // one decoded frame as handed from front to back
  typedef struct packed {
    logic [7:0]        status;
    logic [CODE_W-1:0] hum_code;
    logic [CODE_W-1:0] temp_code;
    logic              crc_ok;
  } frame_t;

  // queue status seen by its producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/humidity_temp_frame_decoder.sv =====
// humidity_temp_frame_decoder: top level of the sensor frame decoder
// instantiates htfd_front, htfd_queue and htfd_back; uses htfd_pkg
//
// Takes one received byte per transfer on the input channel (status byte,
// five data bytes, crc byte; frame_start_i marks a status byte and drops any
// partial frame) and gives one result transfer per crc byte. The front
// accepts one byte every cycle unless the queue is full, running the crc-8
// (poly 0x31, init 0xff) one byte per cycle and packing the two 20-bit codes.
// On the crc byte it pushes a frame record into a two-entry queue; the back
// side multiplies the codes by the fixed scale factors in one stage and
// shifts and offsets them in the output register.
// The input stalls only while the queue is full, i.e. while results back up
// behind a stalled output.
`default_nettype none

module humidity_temp_frame_decoder (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  // byte input channel
  input  wire                                       in_valid_i,
  output logic                                      in_stall_o,
  input  wire  [7:0]                                data_byte_i,
  input  wire                                       frame_start_i,
  // result output channel
  output logic                                      out_valid_o,
  input  wire                                       out_stall_i,
  output logic [7:0]                                status_byte_o,
  output logic [htfd_pkg::CODE_W-1:0]               humidity_code_o,
  output logic [htfd_pkg::CODE_W-1:0]               temperature_code_o,
  output logic [htfd_pkg::HUM_CENTI_W-1:0]          humidity_centi_o,
  output logic signed [htfd_pkg::TEMP_CENTI_W-1:0]  temperature_centi_o,
  output logic                                      crc_ok_o
);
  import htfd_pkg::*;

  // front to queue
  logic          push;
  frame_t        push_data;
  // queue to back
  logic          pop;
  frame_t        head;
  queue_status_t q_status;

  // byte intake, crc and code assembly
  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // decouples byte intake from result delivery
  htfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // scaling pipeline and output register
  htfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .q_status_i          (q_status),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_byte_o       (status_byte_o),
    .humidity_code_o     (humidity_code_o),
    .temperature_code_o  (temperature_code_o),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_centi_o (temperature_centi_o),
    .crc_ok_o            (crc_ok_o)
  );

endmodule

`default_nettype wire

// ===== design/htfd_front.sv =====
// htfd_front: takes frame bytes, tracks position, runs the crc and builds the
// raw codes; pushes one frame record per crc byte; uses htfd_pkg
`default_nettype none

module htfd_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [7:0]            data_byte_i,
  input  wire                   frame_start_i,
  input  htfd_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output htfd_pkg::frame_t      push_data_o
);
  import htfd_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d, pos_eff;
  logic [7:0]        crc_q, crc_d, crc_eff, crc_next;
  logic [7:0]        status_q, status_d;
  logic [CODE_W-1:0] hum_q, hum_d;
  logic [CODE_W-1:0] temp_q, temp_d;
  logic              accept;
  logic              is_data;

  // a full queue holds off every byte
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;

  assign pos_eff  = frame_start_i ? POS_STATUS : pos_q;
  assign crc_eff  = frame_start_i ? CRC_INIT : crc_q;
  assign is_data  = (pos_eff < POS_W'(DATA_BYTES));
  assign crc_next = crc8_byte(crc_eff, data_byte_i);

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    status_d = status_q;
    hum_d    = hum_q;
    temp_d   = temp_q;
    if (accept) begin
      if (is_data) begin
        crc_d = crc_next;
        pos_d = pos_eff + POS_W'(1);
        unique case (pos_eff)
          POS_STATUS:   status_d = data_byte_i;
          POS_HUM_HI:   hum_d = {data_byte_i, 12'd0};
          POS_HUM_MID:  hum_d = hum_q | {8'd0, data_byte_i, 4'd0};
          POS_SPLIT: begin
            hum_d  = hum_q | {16'd0, data_byte_i[7:4]};
            temp_d = {data_byte_i[3:0], 16'd0};
          end
          POS_TEMP_MID: temp_d = temp_q | {4'd0, data_byte_i, 8'd0};
          default:      temp_d = temp_q | {12'd0, data_byte_i};
        endcase
      end else begin
        // crc byte closes the frame
        pos_d = POS_STATUS;
        crc_d = CRC_INIT;
      end
    end
  end

  assign push_o                = accept & ~is_data;
  assign push_data_o.status    = status_q;
  assign push_data_o.hum_code  = hum_q;
  assign push_data_o.temp_code = temp_q;
  assign push_data_o.crc_ok    = (crc_eff == data_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_STATUS;
      crc_q    <= CRC_INIT;
      status_q <= '0;
      hum_q    <= '0;
      temp_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      status_q <= status_d;
      hum_q    <= hum_d;
      temp_q   <= temp_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/htfd_queue.sv =====
// htfd_queue: short register queue of frame records between front and back
// uses htfd_pkg
`default_nettype none

module htfd_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  htfd_pkg::frame_t       push_data_i,
  input  wire                    pop_i,
  output htfd_pkg::frame_t       head_o,
  output htfd_pkg::queue_status_t status_o
);
  import htfd_pkg::*;

  frame_t             entry_q [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QADDR_W:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == (QADDR_W+1)'(QDEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push & ~do_pop) count_d = count_q + (QADDR_W+1)'(1);
    if (do_pop & ~do_push) count_d = count_q - (QADDR_W+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QADDR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QADDR_W'(1);
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/htfd_back.sv =====
// htfd_back: pops frame records, scales the codes in a two-stage pipeline and
// holds the result in the output register; uses htfd_pkg
`default_nettype none

module htfd_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  htfd_pkg::frame_t                head_i,
  input  htfd_pkg::queue_status_t         q_status_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [7:0]                      status_byte_o,
  output logic [htfd_pkg::CODE_W-1:0]     humidity_code_o,
  output logic [htfd_pkg::CODE_W-1:0]     temperature_code_o,
  output logic [htfd_pkg::HUM_CENTI_W-1:0] humidity_centi_o,
  output logic signed [htfd_pkg::TEMP_CENTI_W-1:0] temperature_centi_o,
  output logic                            crc_ok_o
);
  import htfd_pkg::*;

  // multiply stage
  logic                   s1_valid_q;
  frame_t                 s1_frame_q;
  logic [HUM_PROD_W-1:0]  s1_hum_prod_q;
  logic [TEMP_PROD_W-1:0] s1_temp_prod_q;

  // output stage
  logic                    out_valid_q;
  frame_t                  out_frame_q;
  logic [HUM_CENTI_W-1:0]  out_hum_q;
  logic [TEMP_CENTI_W-1:0] out_temp_q;

  logic                  out_ready, s1_ready;
  logic [TEMP_CENTI_W:0] temp_diff;

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign s1_ready  = ~s1_valid_q | out_ready;
  assign pop_o     = ~q_status_i.empty & s1_ready;

  assign temp_diff = {1'b0, s1_temp_prod_q[TEMP_PROD_W-1 -: TEMP_CENTI_W]} - TEMP_OFFSET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= pop_o;
      if (out_ready) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_frame_q     <= head_i;
      s1_hum_prod_q  <= HUM_PROD_W'(head_i.hum_code) * HUM_PROD_W'(HUM_SCALE);
      s1_temp_prod_q <= TEMP_PROD_W'(head_i.temp_code) * TEMP_PROD_W'(TEMP_SCALE);
    end
    if (out_ready & s1_valid_q) begin
      out_frame_q <= s1_frame_q;
      out_hum_q   <= s1_hum_prod_q[HUM_PROD_W-1 -: HUM_CENTI_W];
      out_temp_q  <= temp_diff[TEMP_CENTI_W-1:0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_byte_o       = out_frame_q.status;
  assign humidity_code_o     = out_frame_q.hum_code;
  assign temperature_code_o  = out_frame_q.temp_code;
  assign humidity_centi_o    = out_hum_q;
  assign temperature_centi_o = out_temp_q;
  assign crc_ok_o            = out_frame_q.crc_ok;

endmodule

`default_nettype wire

// ===== design/htfd_checker.sv =====
// htfd_checker: port-level assertions for the frame decoder, bound to the top
// level; uses htfd_pkg
`default_nettype none

module htfd_checker (
  input wire                                      clk_i,
  input wire                                      rst_ni,
  input wire                                      in_valid_i,
  input wire                                      in_stall_o,
  input wire [7:0]                                data_byte_i,
  input wire                                      frame_start_i,
  input wire                                      out_valid_o,
  input wire                                      out_stall_i,
  input wire [7:0]                                status_byte_o,
  input wire [htfd_pkg::CODE_W-1:0]               humidity_code_o,
  input wire [htfd_pkg::CODE_W-1:0]               temperature_code_o,
  input wire [htfd_pkg::HUM_CENTI_W-1:0]          humidity_centi_o,
  input wire signed [htfd_pkg::TEMP_CENTI_W-1:0]  temperature_centi_o,
  input wire                                      crc_ok_o
);
  import htfd_pkg::*;

  logic [HUM_PROD_W-1:0]   hum_prod;
  logic [TEMP_PROD_W-1:0]  temp_prod;
  logic [TEMP_CENTI_W:0]   temp_diff;
  logic                    hum_match, temp_match;

  assign hum_prod   = HUM_PROD_W'(humidity_code_o) * HUM_PROD_W'(HUM_SCALE);
  assign temp_prod  = TEMP_PROD_W'(temperature_code_o) * TEMP_PROD_W'(TEMP_SCALE);
  assign temp_diff  = {1'b0, temp_prod[TEMP_PROD_W-1 -: TEMP_CENTI_W]} - TEMP_OFFSET;
  assign hum_match  = (humidity_centi_o == hum_prod[HUM_PROD_W-1 -: HUM_CENTI_W]);
  assign temp_match = (temperature_centi_o == temp_diff[TEMP_CENTI_W-1:0]);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_byte_o) &&
      $stable(humidity_code_o) && $stable(temperature_code_o) && $stable(crc_ok_o))
    else $error("result changed while stalled");

  // scaled humidity agrees with the raw code it travels with
  a_hum_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hum_match)
    else $error("humidity_centi does not match humidity_code");

  // scaled temperature agrees with the raw code it travels with
  a_temp_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temp_match)
    else $error("temperature_centi does not match temperature_code");

  // a result that newly appears comes from an earlier byte transfer
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 3))
    else $error("result without a preceding byte transfer");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for humidity_temp_frame_decoder, byte frames in, decoded results out
// walks a directed stimulus table, then random frames under shifting idle patterns,
// and checks each result against a local decoder model; uses htfd_pkg for widths

module tb;
  import htfd_pkg::CODE_W;
  import htfd_pkg::HUM_CENTI_W;
  import htfd_pkg::TEMP_CENTI_W;
  import htfd_pkg::POS_W;
  import htfd_pkg::POS_STATUS;
  import htfd_pkg::POS_HUM_HI;
  import htfd_pkg::POS_HUM_MID;
  import htfd_pkg::POS_SPLIT;
  import htfd_pkg::POS_TEMP_MID;
  import htfd_pkg::POS_CRC;

  // crc-8 seed and polynomial, msb first
  localparam logic [7:0] CRC_SEED   = 8'hFF;
  localparam logic [7:0] CRC_POLY31 = 8'h31;
  localparam int unsigned RANDOM_PER_PHASE = 584;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  // one decoded frame as the block should present it
  typedef struct packed {
    logic [7:0]                     status;
    logic [CODE_W-1:0]              hum_code;
    logic [CODE_W-1:0]              temp_code;
    logic [HUM_CENTI_W-1:0]         hum_centi;
    logic signed [TEMP_CENTI_W-1:0] temp_centi;
    logic                           crc_ok;
  } frame_result_t;

  // one row of the directed table; a pinned row carries hand-typed field values
  typedef struct {
    logic [7:0]    data;
    logic          start;
    bit            fill_crc;
    bit            pinned;
    frame_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni        = 1'b0;
  logic in_valid_i    = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic frame_start_i = 1'b0;
  logic out_stall_i   = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [7:0] status_byte_o;
  logic [CODE_W-1:0] humidity_code_o;
  logic [CODE_W-1:0] temperature_code_o;
  logic [HUM_CENTI_W-1:0] humidity_centi_o;
  logic signed [TEMP_CENTI_W-1:0] temperature_centi_o;
  logic crc_ok_o;

  humidity_temp_frame_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .frame_start_i       (frame_start_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_byte_o       (status_byte_o),
    .humidity_code_o     (humidity_code_o),
    .temperature_code_o  (temperature_code_o),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_centi_o (temperature_centi_o),
    .crc_ok_o            (crc_ok_o)
  );

  // decoder model state, mirrors the block after each accepted byte
  logic [POS_W-1:0]  frame_pos = POS_STATUS;
  logic [7:0]        crc_run   = CRC_SEED;
  logic [7:0]        status_acc = 8'h00;
  logic [CODE_W-1:0] hum_acc   = '0;
  logic [CODE_W-1:0] temp_acc  = '0;

  frame_result_t frames_due[$];
  stim_row_t     directed_rows[$];

  // pinned expectation travelling with the byte on the input channel
  bit            pinned_now = 1'b0;
  frame_result_t pinned_want = '0;

  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 72;
  int unsigned bytes_sent    = 0;
  int unsigned directed_sent = 0;
  int unsigned frames_seen   = 0;
  int unsigned good_crc_seen = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc8_poly31(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY31) : {c[6:0], 1'b0};
    return c;
  endfunction

  // advance the model by one byte; returns 1 when the byte closes a frame
  function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                     output frame_result_t r);
    logic [63:0] hum_prod;
    logic [63:0] temp_prod;
    int          temp_scaled;
    r = '0;
    // frame start drops any partial frame
    if (fs) begin
      frame_pos = POS_STATUS;
      crc_run   = CRC_SEED;
    end
    if (frame_pos < POS_CRC) begin
      crc_run = crc8_poly31(crc_run, b);
      case (frame_pos)
        POS_STATUS:   status_acc = b;
        POS_HUM_HI:   hum_acc = {b, 12'h000};
        POS_HUM_MID:  hum_acc = hum_acc | {8'h00, b, 4'h0};
        POS_SPLIT: begin
          hum_acc  = hum_acc | {16'h0000, b[7:4]};
          temp_acc = {b[3:0], 16'h0000};
        end
        POS_TEMP_MID: temp_acc = temp_acc | {4'h0, b, 8'h00};
        default:      temp_acc = temp_acc | {12'h000, b};
      endcase
      frame_pos = frame_pos + 1'b1;
      return 1'b0;
    end
    // crc byte: scale the codes exactly, then back to the start of a frame
    hum_prod    = 64'(hum_acc) * 64'd10000;
    temp_prod   = 64'(temp_acc) * 64'd20000;
    temp_scaled = int'(temp_prod >> 20) - 5000;
    r.status     = status_acc;
    r.hum_code   = hum_acc;
    r.temp_code  = temp_acc;
    r.hum_centi  = HUM_CENTI_W'(hum_prod >> 20);
    r.temp_centi = TEMP_CENTI_W'(temp_scaled);
    r.crc_ok     = (crc_run == b);
    frame_pos = POS_STATUS;
    crc_run   = CRC_SEED;
    return 1'b1;
  endfunction

  // mostly uniform bytes, with the all-zero and all-one extremes boosted
  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_row(input logic [7:0] d, input logic s, input bit fill = 1'b0);
    stim_row_t row;
    row.data     = d;
    row.start    = s;
    row.fill_crc = fill;
    row.pinned   = 1'b0;
    row.want     = '0;
    directed_rows.push_back(row);
  endtask

  // pin the fields of the frame closed by the last row; crc flag still from the model
  task automatic pin_frame(input logic [7:0] st, input logic [CODE_W-1:0] hc,
                           input logic [CODE_W-1:0] tc, input int hcent, input int tcent);
    int last;
    last = directed_rows.size() - 1;
    directed_rows[last].pinned          = 1'b1;
    directed_rows[last].want.status     = st;
    directed_rows[last].want.hum_code   = hc;
    directed_rows[last].want.temp_code  = tc;
    directed_rows[last].want.hum_centi  = HUM_CENTI_W'(hcent);
    directed_rows[last].want.temp_centi = TEMP_CENTI_W'(tcent);
  endtask

  // one byte transfer; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic s, input bit fill = 1'b0,
                           input bit pin = 1'b0, input frame_result_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    // a filled crc byte takes the running crc so the frame checks good
    if (fill) d = crc_run;
    pinned_now  = pin;
    pinned_want = want;
    in_valid_i    <= 1'b1;
    data_byte_i   <= d;
    frame_start_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // input transfer: run the model, queue the expected frame
  always @(posedge clk_i) begin
    frame_result_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (decode_byte(data_byte_i, frame_start_i, r)) begin
        if (pinned_now) begin
          pinned_want.crc_ok = r.crc_ok;
          frames_due.push_back(pinned_want);
        end else begin
          frames_due.push_back(r);
        end
      end
    end
  end

  // output transfer: compare against the oldest expected frame
  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        $error("result with nothing expected: status %0h", status_byte_o);
        mismatches++;
      end else begin
        exp_r = frames_due.pop_front();
        check_field("status_byte", exp_r.status, status_byte_o);
        check_field("humidity_code", exp_r.hum_code, humidity_code_o);
        check_field("temperature_code", exp_r.temp_code, temperature_code_o);
        check_field("humidity_centi", exp_r.hum_centi, humidity_centi_o);
        check_field("temperature_centi", $signed(exp_r.temp_centi),
                    $signed(temperature_centi_o));
        check_field("crc_ok", exp_r.crc_ok, crc_ok_o);
        frames_seen++;
        if (crc_ok_o) good_crc_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned kind;
    int unsigned n;
    logic        start_bit;

    // all-zero frame right after reset, no frame start: status taken from reset position
    add_row(8'h00, 1'b0);
    repeat (5) add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1);
    pin_frame(8'h00, 20'h00000, 20'h00000, 0, -5000);
    // all-one frame straight after a crc byte, still no frame start, bad crc byte
    add_row(8'hFF, 1'b0);
    repeat (5) add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    pin_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 9999, 14999);
    // partial frame dropped by a new frame start
    add_row(8'h5A, 1'b1);
    add_row(8'h12, 1'b0);
    add_row(8'h34, 1'b0);
    // mid-scale codes, split nibble byte, good crc
    add_row(8'hA5, 1'b1);
    add_row(8'h80, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h08, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1);
    pin_frame(8'hA5, 20'h80000, 20'h80000, 5000, 5000);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].fill_crc,
                directed_rows[i].pinned, directed_rows[i].want);
    end
    directed_sent = bytes_sent;

    // random part: sender-light/receiver-heavy, then swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 11; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_end = directed_sent + (phase + 1) * RANDOM_PER_PHASE;
      while (bytes_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          // well-formed frame; frame start optional only when already at a frame boundary
          start_bit = (frame_pos == POS_STATUS) ? 1'($urandom_range(0, 1)) : 1'b1;
          send_byte(rand_byte(), start_bit);
          repeat (5) send_byte(rand_byte(), 1'b0);
          if ($urandom_range(0, 3) != 0) send_byte(8'h00, 1'b0, 1'b1);
          else send_byte(rand_byte(), 1'b0);
        end else if (kind < 92) begin
          // truncated frame; the next well-formed or truncated frame restarts it
          n = $urandom_range(1, 6);
          send_byte(rand_byte(), 1'b1);
          repeat (n - 1) send_byte(rand_byte(), 1'b0);
        end else begin
          // stray byte with a random frame start
          send_byte(rand_byte(), 1'($urandom_range(0, 1)));
        end
      end
      // hold off until the block has handed over every pending frame
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (frames_due.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("summary: %0d bytes (%0d directed), %0d frames checked, %0d with good crc",
             bytes_sent, directed_sent, frames_seen, good_crc_seen);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/htfd_pkg.sv
design/htfd_front.sv
design/htfd_queue.sv
design/htfd_back.sv
design/humidity_temp_frame_decoder.sv
design/htfd_checker.sv
tb/tb.sv
